### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte- and word-level functions for the AES block.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRoundKeys = 15;
  localparam int unsigned RkIdxW       = 4;
  localparam int unsigned WordIdxW     = 6;
  localparam int unsigned CfgIdxW      = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_0_7    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_8_15   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_16_23  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_24_31  = 3'd4;

  // key length codes
  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FETCH,
    ST_INIT,
    ST_ROUND,
    ST_LAST,
    ST_DONE
  } aes_state_t;

  typedef logic [7:0] aes_byte_t;

  function automatic aes_byte_t sbox(input aes_byte_t x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic aes_byte_t inv_sbox(input aes_byte_t x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[x];
  endfunction

  // multiply by x in GF(2^8)
  function automatic aes_byte_t xt(input aes_byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // one column of MixColumns or its inverse, row 0 in the top byte
  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    aes_byte_t a0, a1, a2, a3, b0, b1, b2, b3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    if (inv) begin
      // pre-multiply so that the forward matrix yields the inverse
      u  = xt(xt(a0 ^ a2));
      v  = xt(xt(a1 ^ a3));
      a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
    end
    b0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
    b1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
    b2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
    b3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    return {b0, b1, b2, b3};
  endfunction

endpackage

### rtl/aes_if.sv
// ----------------------------------------------------------------------------
// AES channel interfaces
// Valid/ready channels for blocks in, results out and register writes.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, kind, block_high, block_low, input ready);
  modport sink   (input valid, kind, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/aes_block_cipher_enc_dec.sv
// ----------------------------------------------------------------------------
// AES block cipher, encrypt and decrypt
// Iterative AES-128/192/256 with a key schedule store and one round unit.
//
//   channel  dir  content
//   din      in   kind, block_high, block_low
//   dout     out  result_high, result_low
//   cfg      in   index, data (register write)
//
// One round per cycle through the shared round unit: INIT does the key
// addition, ROUND the Nr-1 full rounds and LAST the last round; then DONE holds
// the result until it is taken and the block returns to IDLE.
// After reset or a write to the key length or a key register the first item
// first expands the schedule, one key word per cycle, then fetches the first
// round key in FETCH. Reset clears control state and the key registers only.
// The block takes no item from acceptance until its result is taken.
// ----------------------------------------------------------------------------
module aes_block_cipher_enc_dec
  import aes_pkg::*;
(
  input  logic clk,
  input  logic rst,
  aes_in_if.sink    din,
  aes_out_if.source dout,
  aes_cfg_if.sink   cfg
);

  aes_state_t state, state_next;

  logic [1:0]  key_length;
  logic [63:0] key_regs [4];
  logic        schedule_ready;

  logic [127:0] rk_mem [NumRoundKeys];
  logic [127:0] rk_rd;
  logic [RkIdxW-1:0] rk_addr;

  // expansion
  logic [31:0]  win [8];           // last Nk words, win[0] newest
  logic [WordIdxW-1:0] wcnt;       // word index being made
  logic [2:0]   wmod;              // wcnt mod Nk
  logic [7:0]   rcon;
  logic [95:0]  row_acc;           // first three words of current round key

  logic [3:0]   nk;
  logic [RkIdxW-1:0] nr;
  logic [WordIdxW-1:0] total;

  logic [127:0] st;
  logic         decrypt;
  logic [RkIdxW-1:0] rnd;

  assign nk = (key_length == KEY_128) ? 4'd4 : (key_length == KEY_192) ? 4'd6 : 4'd8;
  assign nr    = RkIdxW'(nk + 4'd6);
  assign total = WordIdxW'({nr, 2'b00} + 6'd4);

  assign cfg.ready = (state == ST_IDLE);
  assign din.ready = (state == ST_IDLE) && !cfg.valid;
  assign dout.valid       = (state == ST_DONE);
  assign dout.result_high = st[127:64];
  assign dout.result_low  = st[63:0];

  // next key word
  logic [31:0] wt, wnew;
  always_comb begin
    wt = win[0];
    if (wmod == 3'd0)
      wt = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h0};
    else if (nk == 4'd8 && wmod == 3'd4)
      wt = sub_word(win[0]);
    wnew = win[3'(nk - 4'd1)] ^ wt;
  end

  // word written this cycle: the key itself for the first Nk words
  logic [31:0] wo;
  always_comb begin
    wo = wnew;
    if (wcnt < WordIdxW'(nk))
      wo = win[3'(nk - 4'd1 - wcnt[3:0])];
  end

  // round-key read address for the step about to run
  always_comb begin
    rk_addr = '0;
    unique case (state)
      ST_IDLE:  rk_addr = (din.kind) ? nr : '0;
      ST_FETCH: rk_addr = rnd;
      ST_INIT,
      ST_ROUND: rk_addr = decrypt ? RkIdxW'(rnd - 4'd1) : RkIdxW'(rnd + 4'd1);
      default:  rk_addr = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:
        if (din.valid && din.ready) state_next = schedule_ready ? ST_INIT : ST_EXPAND;
      ST_EXPAND:
        if (wcnt == total - 6'd1) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_INIT;
      ST_INIT:  state_next = ST_ROUND;
      ST_ROUND:
        if ((decrypt && rnd == 4'd1) || (!decrypt && rnd == nr - 4'd1))
          state_next = ST_LAST;
      ST_LAST:  state_next = ST_DONE;
      ST_DONE:
        if (dout.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // round unit
  logic [127:0] sr_out, sb_out, mc_out, rnd_out;
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sr_out[127-8*(c*4+r) -: 8] = decrypt ?
          st[127-8*((((c+4-r)&3)*4)+r) -: 8] : st[127-8*((((c+r)&3)*4)+r) -: 8];
    for (int i = 0; i < 16; i++)
      sb_out[127-8*i -: 8] = decrypt ? inv_sbox(sr_out[127-8*i -: 8])
                                     : sbox(sr_out[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      mc_out[127-32*c -: 32] = decrypt ? mix_col(sb_out[127-32*c -: 32] ^ rk_rd[127-32*c -: 32], 1'b1)
                                       : mix_col(sb_out[127-32*c -: 32], 1'b0);
    if (state == ST_LAST)      rnd_out = sb_out ^ rk_rd;
    else if (decrypt)          rnd_out = mc_out;
    else                       rnd_out = mc_out ^ rk_rd;
  end

  // round-key store
  always_ff @(posedge clk) begin
    rk_rd <= rk_mem[rk_addr];
    if (state == ST_EXPAND && wcnt[1:0] == 2'd3)
      rk_mem[wcnt[WordIdxW-1:2]] <= {row_acc, wo};
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      key_length     <= '0;
      schedule_ready <= 1'b0;
      for (int i = 0; i < 4; i++) key_regs[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_KEY_LENGTH: begin key_length  <= cfg.data[1:0]; schedule_ready <= 1'b0; end
          REG_KEY_0_7:    begin key_regs[0] <= cfg.data;      schedule_ready <= 1'b0; end
          REG_KEY_8_15:   begin key_regs[1] <= cfg.data;      schedule_ready <= 1'b0; end
          REG_KEY_16_23:  begin key_regs[2] <= cfg.data;      schedule_ready <= 1'b0; end
          REG_KEY_24_31:  begin key_regs[3] <= cfg.data;      schedule_ready <= 1'b0; end
          default: ;
        endcase
      end
      if (state == ST_EXPAND && state_next == ST_FETCH) schedule_ready <= 1'b1;
    end
  end

  // expansion and cipher state
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (din.valid && din.ready) begin
        st      <= {din.block_high, din.block_low};
        decrypt <= din.kind;
        // key words, newest first
        for (int i = 0; i < 8; i++)
          win[i] <= (i < nk) ? ((((nk - 4'd1 - i[3:0]) & 4'd1) != 0) ?
                      key_regs[2'((nk - 4'd1 - i[3:0]) >> 1)][31:0] :
                      key_regs[2'((nk - 4'd1 - i[3:0]) >> 1)][63:32]) : 32'h0;
        wcnt <= '0;
        wmod <= 3'd0;
        rcon <= RCON_INIT;
      end
      ST_EXPAND: begin
        // first Nk words are the key itself
        if (wcnt >= WordIdxW'(nk)) begin
          for (int i = 7; i > 0; i--) win[i] <= win[i-1];
          win[0] <= wnew;
          if (wmod == 3'd0) rcon <= xt(rcon);
          wmod <= (wmod == 3'(nk - 4'd1)) ? 3'd0 : wmod + 3'd1;
        end
        unique case (wcnt[1:0])
          2'd0: row_acc[95:64] <= wo;
          2'd1: row_acc[63:32] <= wo;
          2'd2: row_acc[31:0]  <= wo;
          default: ;
        endcase
        wcnt <= wcnt + 6'd1;
      end
      ST_INIT: begin
        st  <= st ^ rk_rd;
        rnd <= decrypt ? RkIdxW'(rnd - 4'd1) : RkIdxW'(rnd + 4'd1);
      end
      ST_ROUND: begin
        st  <= rnd_out;
        rnd <= decrypt ? RkIdxW'(rnd - 4'd1) : RkIdxW'(rnd + 4'd1);
      end
      ST_LAST: st <= rnd_out;
      default: ;
    endcase
    if (state == ST_IDLE && din.valid && din.ready)
      rnd <= din.kind ? nr : '0;
  end

endmodule

### sim/aes_checker.sv
// ----------------------------------------------------------------------------
// AES result checker
// Watches the block, config and result channels, computes the expected cipher
// output for every accepted block and compares it with the returned result.
// ----------------------------------------------------------------------------
module aes_checker
  import aes_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  aes_in_if.sink    din,
  aes_out_if.sink   dout,
  aes_cfg_if.sink   cfg,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] state_t [16];

  logic [1:0]   key_len;
  logic [63:0]  key_word [4];
  logic [127:0] round_key [15];
  int unsigned  nr;
  logic [127:0] expected_q [$];
  logic [7:0]   fwd_tab [256];
  logic [7:0]   inv_tab [256];

  // substitution tables built from the affine/inverse definition
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  initial begin
    logic [7:0] p, q, s;
    for (int i = 0; i < 256; i++) begin
      p = 8'(i);
      q = 0;
      if (p != 0)
        for (int j = 1; j < 256; j++) if (gf_mul(p, 8'(j)) == 8'h01) q = 8'(j);
      s = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ 8'h63;
      fwd_tab[i] = s;
      inv_tab[s] = p;
    end
  end

  function automatic logic [31:0] sub32(logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  // key schedule from the current registers
  task automatic expand_key();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    int nk, total;
    nk = (key_len == KEY_128) ? 4 : (key_len == KEY_192) ? 6 : 8;
    nr = nk + 6;
    total = 4 * (nr + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      w[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = w[i - 1];
      if (i % nk == 0) begin
        t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub32(t);
      end
      w[i] = w[i - nk] ^ t;
    end
    for (int r = 0; r <= nr; r++)
      round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic state_t add_rk(state_t s, logic [127:0] k);
    for (int i = 0; i < 16; i++) s[i] ^= k[127 - 8*i -: 8];
    return s;
  endfunction

  function automatic state_t shift(state_t s, bit inverse);
    state_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c*4 + r] = s[(inverse ? (c + 4 - r) : (c + r)) % 4 * 4 + r];
    return t;
  endfunction

  function automatic state_t mix(state_t s, bit inverse);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] v;
    if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[c*4 + k];
      for (int r = 0; r < 4; r++) begin
        v = 0;
        for (int k = 0; k < 4; k++) v ^= gf_mul(a[k], m[(k + 4 - r) % 4]);
        s[c*4 + r] = v;
      end
    end
    return s;
  endfunction

  function automatic state_t subst(state_t s, bit inverse);
    for (int i = 0; i < 16; i++) s[i] = inverse ? inv_tab[s[i]] : fwd_tab[s[i]];
    return s;
  endfunction

  function automatic logic [127:0] cipher_block(logic decrypt, logic [127:0] blk);
    state_t s;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
    if (!decrypt) begin
      s = add_rk(s, round_key[0]);
      for (int r = 1; r < nr; r++)
        s = add_rk(mix(shift(subst(s, 0), 0), 0), round_key[r]);
      s = add_rk(shift(subst(s, 0), 0), round_key[nr]);
    end else begin
      s = add_rk(s, round_key[nr]);
      for (int r = nr - 1; r >= 1; r--)
        s = mix(add_rk(subst(shift(s, 1), 1), round_key[r]), 1);
      s = add_rk(subst(shift(s, 1), 1), round_key[0]);
    end
    for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = s[i];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // predict on accepted blocks, compare accepted results
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst) begin
      key_len <= KEY_128;
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      errors = 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KEY_LENGTH: key_len <= cfg.data[1:0];
          REG_KEY_0_7:    key_word[0] <= cfg.data;
          REG_KEY_8_15:   key_word[1] <= cfg.data;
          REG_KEY_16_23:  key_word[2] <= cfg.data;
          REG_KEY_24_31:  key_word[3] <= cfg.data;
          default: ;
        endcase
      end
      if (din.valid && din.ready) begin
        expand_key();
        expected_q.push_back(cipher_block(din.kind, {din.block_high, din.block_low}));
      end
      if (dout.valid && dout.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", dout.result_high, '0);
        end else begin
          want = expected_q.pop_front();
          if (dout.result_high !== want[127:64]) report("result_high", dout.result_high, want[127:64]);
          if (dout.result_low !== want[63:0]) report("result_low", dout.result_low, want[63:0]);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// AES block cipher regression
// Drives key settings and blocks of both kinds into the cipher with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic clk, rst;
  int   errors, pending;
  int   idle_cycles;
  bit   quiet, hold_off;

  aes_in_if  din();
  aes_out_if dout();
  aes_cfg_if cfg();

  aes_block_cipher_enc_dec u_dut (.clk, .rst, .din, .dout, .cfg);
  aes_checker u_chk (.clk, .rst, .din, .dout, .cfg, .errors, .pending);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("aes_block_cipher_enc_dec regression: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off when asked
  always @(posedge clk) begin
    if (rst) dout.ready <= 1'b0;
    else if (hold_off) dout.ready <= 1'b0;
    else dout.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 36);
  end

  // valid stays high after the write; the caller drops it when done
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // valid stays high after the item unless a gap or a drain follows
  task automatic send_block(logic k, logic [63:0] hi, logic [63:0] lo);
    while (!quiet && $urandom_range(99) < 36) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid      <= 1'b1;
    din.kind       <= k;
    din.block_high <= hi;
    din.block_low  <= lo;
    do @(posedge clk); while (!din.ready);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // wait for all results, then some settle time before a register write
  task automatic drain();
    din.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_key(logic [1:0] len, logic [63:0] k0, logic [63:0] k1,
                         logic [63:0] k2, logic [63:0] k3);
    drain();
    write_reg(REG_KEY_LENGTH, {62'd0, len});
    write_reg(REG_KEY_0_7, k0);
    write_reg(REG_KEY_8_15, k1);
    write_reg(REG_KEY_16_23, k2);
    write_reg(REG_KEY_24_31, k3);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [63:0] pat;
    rst = 1'b1;
    din.valid = 1'b0; din.kind = 1'b0; din.block_high = '0; din.block_low = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    quiet = 1'b0; hold_off = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key, extremes, known vectors, all key lengths
    send_block(1'b0, '0, '0);
    send_block(1'b1, '1, '1);
    set_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    set_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    set_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
            64'h18191a1b1c1d1e1f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    // key length three acts as 256-bit
    set_key(2'd3, '1, '1, '1, '1);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '0, '0);
    // out-of-range index leaves the schedule alone
    drain();
    write_reg(3'd5, '1);
    write_reg(3'd7, '0);
    cfg.valid <= 1'b0;
    send_block(1'b0, 64'h8000000000000000, 64'h1);

    // random phases, each with a fresh key; phase 3 rewrites one key register again
    for (int ph = 0; ph < 20; ph++) begin
      set_key(2'($urandom_range(3)), rnd64(), rnd64(), rnd64(), rnd64());
      if (ph == 3) begin
        drain();
        write_reg(REG_KEY_8_15, rnd64());
        cfg.valid <= 1'b0;
      end
      quiet = (ph == 5);
      if (ph == 7) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 100; n++) begin
        pat = rnd64();
        case ($urandom_range(9))
          0: pat = '0;
          1: pat = '1;
          default: ;
        endcase
        send_block(1'($urandom_range(1)), pat, rnd64());
      end
    end
    quiet = 1'b0;

    drain();
    if (errors == 0)
      $display("aes_block_cipher_enc_dec regression: pass");
    else
      $display("aes_block_cipher_enc_dec regression: fail");
    $finish;
  end
endmodule
